// ===== src/tkn_pkg.sv =====
// tkn_pkg: shared widths, opcodes and constants for the top-k nearest keeper
// used by the channel interfaces and by top_k_nearest_max_heap
package tkn_pkg;

   localparam int OPCODE_BITS   = 2;
   localparam int ID_FIELD_BITS = 16;
   localparam int DIST_BITS     = 32;
   localparam int SLOT_BITS     = 4;
   localparam int COUNT_BITS    = 5;

   localparam int DEFAULT_MAX_KEEP = 16;
   localparam int DEFAULT_ID_BITS  = 16;

   localparam logic [COUNT_BITS-1:0] KEEP_RESET = COUNT_BITS'(16);
   localparam logic [DIST_BITS-1:0]  DIST_NONE  = '1;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

endpackage

// ===== src/tkn_req_if.sv =====
// tkn_req_if: request channel (opcode, candidate, slot) with valid/ready
// depends on tkn_pkg for field widths
interface tkn_req_if import tkn_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [OPCODE_BITS-1:0]   opcode;
   logic [ID_FIELD_BITS-1:0] item_id;
   logic [DIST_BITS-1:0]     distance;
   logic [SLOT_BITS-1:0]     slot;

   modport source (output valid, output opcode, output item_id, output distance,
                   output slot, input ready);
   modport sink   (input valid, input opcode, input item_id, input distance,
                   input slot, output ready);

endinterface

// ===== src/tkn_rsp_if.sv =====
// tkn_rsp_if: response channel (count, worst distance, read data) with valid/ready
// depends on tkn_pkg for field widths
interface tkn_rsp_if import tkn_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [COUNT_BITS-1:0]    entry_count_out;
   logic [DIST_BITS-1:0]     worst_distance;
   logic                     accepted;
   logic [ID_FIELD_BITS-1:0] read_id;
   logic [DIST_BITS-1:0]     read_distance;

   modport source (output valid, output entry_count_out, output worst_distance,
                   output accepted, output read_id, output read_distance,
                   input ready);
   modport sink   (input valid, input entry_count_out, input worst_distance,
                   input accepted, input read_id, input read_distance,
                   output ready);

endinterface

// ===== src/top_k_nearest_max_heap.sv =====
// top_k_nearest_max_heap: keeps the k smallest-distance candidates in a max-heap
// clear and rejected insert go from idle straight to the done state, read passes
// through the read state, and an accepted insert sifts one heap level per cycle
// through the heap memory and its compare path (up with room, down from the root)
// one item in flight; ready again once the done state fills the response registers
// reset: count 0, keep_count 16, heap contents undefined until written
module top_k_nearest_max_heap import tkn_pkg::*; #(
   parameter int MAX_KEEP = DEFAULT_MAX_KEEP,
   parameter int ID_BITS  = DEFAULT_ID_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   tkn_req_if.sink               req_ch,
   tkn_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [COUNT_BITS-1:0] csr_wdata
);

   localparam int IDX_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int CHILD_W    = IDX_W + 2;
   localparam int STORE_BITS = (ID_BITS < ID_FIELD_BITS) ? ID_BITS : ID_FIELD_BITS;
   localparam logic [COUNT_BITS-1:0] CAP_MAX =
      COUNT_BITS'((MAX_KEEP > 31) ? 31 : MAX_KEEP);

   typedef struct packed {
      logic [STORE_BITS-1:0] id;
      logic [DIST_BITS-1:0]  key;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_UP   = 5'b00010,
      S_DOWN = 5'b00100,
      S_READ = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [COUNT_BITS-1:0]    keep_ff;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   entry_type                car_ff, car_in;
   logic [DIST_BITS-1:0]     root_ff, root_in;
   logic                     hit_ff, hit_in;
   logic                     acc_ff, acc_in;
   logic [ID_FIELD_BITS-1:0] rid_ff, rid_in;
   logic [DIST_BITS-1:0]     rdist_ff, rdist_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic [DIST_BITS-1:0]     rsp_worst_ff, rsp_worst_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   logic [ID_FIELD_BITS-1:0] rsp_rid_ff, rsp_rid_in;
   logic [DIST_BITS-1:0]     rsp_rdist_ff, rsp_rdist_in;

   // heap memory: one write port, two registered read ports
   entry_type                mem [MAX_KEEP];
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   entry_type                mem_wdata;
   logic [IDX_W-1:0]         rd_addr_a, rd_addr_b;
   entry_type                rd_a_ff, rd_b_ff;

   logic [COUNT_BITS-1:0]    cap;
   entry_type                new_entry;
   logic [IDX_W-1:0]         up_parent, next_parent;
   logic [CHILD_W-1:0]       cl, cr, nl, nr;
   logic                     take_l, take_r;
   logic [DIST_BITS-1:0]     big_l_dist;
   logic                     load_rsp;

   always_comb begin
      if (keep_ff == '0) begin
         cap = COUNT_BITS'(1);
      end else if (keep_ff > CAP_MAX) begin
         cap = CAP_MAX;
      end else begin
         cap = keep_ff;
      end
   end

   assign new_entry = entry_type'{id: req_ch.item_id[STORE_BITS-1:0],
                                  key: req_ch.distance};
   assign up_parent = (pos_ff - 1'b1) >> 1;
   assign cl        = {1'b0, pos_ff, 1'b1};
   assign cr        = cl + 1'b1;

   // strict compares keep ties in place, as in the sift rules
   assign take_l     = (cl < CHILD_W'(count_ff)) && (rd_a_ff.key > car_ff.key);
   assign big_l_dist = take_l ? rd_a_ff.key : car_ff.key;
   assign take_r     = (cr < CHILD_W'(count_ff)) && (rd_b_ff.key > big_l_dist);

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      car_in       = car_ff;
      hit_in       = hit_ff;
      acc_in       = acc_ff;
      rid_in       = rid_ff;
      rdist_in     = rdist_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      mem_wdata    = car_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in = rsp_count_ff;
      rsp_worst_in = rsp_worst_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_rid_in   = rsp_rid_ff;
      rsp_rdist_in = rsp_rdist_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               acc_in   = 1'b0;
               rid_in   = '0;
               rdist_in = '0;
               state_in = S_DONE;
               unique case (req_ch.opcode)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_INSERT: begin
                     if (count_ff < cap) begin
                        pos_in   = IDX_W'(count_ff);
                        car_in   = new_entry;
                        count_in = count_ff + 1'b1;
                        acc_in   = 1'b1;
                        state_in = S_UP;
                     end else if (count_ff != '0 && req_ch.distance < root_ff) begin
                        pos_in   = '0;
                        car_in   = new_entry;
                        acc_in   = 1'b1;
                        state_in = S_DOWN;
                     end
                  end
                  OP_READ: begin
                     hit_in   = req_ch.slot < count_ff;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_UP: begin
            mem_we = 1'b1;
            if (pos_ff == '0) begin
               state_in = S_DONE;
            end else if (car_ff.key > rd_a_ff.key) begin
               // parent moves down into the hole
               mem_wdata = rd_a_ff;
               pos_in    = up_parent;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DOWN: begin
            mem_we = 1'b1;
            if (take_r) begin
               mem_wdata = rd_b_ff;
               pos_in    = IDX_W'(cr);
            end else if (take_l) begin
               mem_wdata = rd_a_ff;
               pos_in    = IDX_W'(cl);
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            rid_in   = hit_ff ? ID_FIELD_BITS'(rd_a_ff.id) : '0;
            rdist_in = hit_ff ? rd_a_ff.key : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_worst_in = (count_ff == '0) ? DIST_NONE : root_ff;
               rsp_acc_in   = acc_ff;
               rsp_rid_in   = rid_ff;
               rsp_rdist_in = rdist_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // root copy tracks every write to slot zero
   assign root_in = (mem_we && mem_waddr == '0) ? mem_wdata.key : root_ff;

   // read addresses follow the next position
   assign next_parent = (pos_in == '0) ? '0 : IDX_W'((pos_in - 1'b1) >> 1);
   assign nl          = {1'b0, pos_in, 1'b1};
   assign nr          = nl + 1'b1;

   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      if (state_in == S_UP) begin
         rd_addr_a = next_parent;
      end else if (state_in == S_DOWN) begin
         rd_addr_a = (nl < CHILD_W'(count_in)) ? IDX_W'(nl) : '0;
         rd_addr_b = (nr < CHILD_W'(count_in)) ? IDX_W'(nr) : '0;
      end else if (state_ff == S_IDLE && state_in == S_READ) begin
         rd_addr_a = (req_ch.slot < count_ff) ? IDX_W'(req_ch.slot) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            keep_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      car_ff       <= car_in;
      root_ff      <= root_in;
      hit_ff       <= hit_in;
      acc_ff       <= acc_in;
      rid_ff       <= rid_in;
      rdist_ff     <= rdist_in;
      rsp_count_ff <= rsp_count_in;
      rsp_worst_ff <= rsp_worst_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_rid_ff   <= rsp_rid_in;
      rsp_rdist_ff <= rsp_rdist_in;
   end

   assign req_ch.ready           = (state_ff == S_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.entry_count_out = rsp_count_ff;
   assign rsp_ch.worst_distance  = rsp_worst_ff;
   assign rsp_ch.accepted        = rsp_acc_ff;
   assign rsp_ch.read_id         = rsp_rid_ff;
   assign rsp_ch.read_distance   = rsp_rdist_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_MAX)
      else $error("heap count above capacity limit");

   a_write_in_set: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (COUNT_BITS'(mem_waddr) < count_ff))
      else $error("heap write outside the held entries");

   a_down_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DOWN) |-> (count_ff != '0))
      else $error("sift down on an empty heap");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.opcode == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear beat left entries behind");

   a_empty_worst: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.entry_count_out == '0) |-> (rsp_ch.worst_distance == DIST_NONE))
      else $error("empty set must report all-ones worst distance");

endmodule
